>>> sv/ibm_pkg.sv
// shared types and codes for the i2c bit level master
// no dependencies
`default_nettype none

package ibm_pkg;

	localparam int unsigned HalfW = 16;
	localparam int unsigned PollW = 8;
	localparam int unsigned ByteW = 8;
	localparam int unsigned OpW = 3;
	localparam int unsigned PhaseW = 4;
	localparam int unsigned CmdW = 3;
	localparam int unsigned BitCntW = 4;
	localparam int unsigned InDataW = 16;
	localparam int unsigned OutDataW = 16;
	localparam int unsigned ApbAddrW = 3;
	localparam int unsigned ApbDataW = 32;

	localparam logic [HalfW-1:0] HalfReset = 16'd100;
	localparam logic [PollW-1:0] PollReset = 8'd250;
	localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;

	localparam logic [OpW-1:0] OP_NONE = 3'd0;
	localparam logic [OpW-1:0] OP_START = 3'd1;
	localparam logic [OpW-1:0] OP_STOP = 3'd2;
	localparam logic [OpW-1:0] OP_WRITE = 3'd3;
	localparam logic [OpW-1:0] OP_READ = 3'd4;

	localparam logic [CmdW-1:0] CMD_NONE = 3'd0;
	localparam logic [CmdW-1:0] CMD_START = 3'd1;
	localparam logic [CmdW-1:0] CMD_STOP = 3'd2;
	localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
	localparam logic [CmdW-1:0] CMD_READ_NACK = 3'd4;
	localparam logic [CmdW-1:0] CMD_READ_ACK = 3'd5;

	localparam logic [PhaseW-1:0] PH_IDLE = 4'd0;
	localparam logic [PhaseW-1:0] PH_ST1 = 4'd1;
	localparam logic [PhaseW-1:0] PH_ST2 = 4'd2;
	localparam logic [PhaseW-1:0] PH_SP1 = 4'd3;
	localparam logic [PhaseW-1:0] PH_SP2 = 4'd4;
	localparam logic [PhaseW-1:0] PH_SP3 = 4'd5;
	localparam logic [PhaseW-1:0] PH_W1 = 4'd6;
	localparam logic [PhaseW-1:0] PH_W2 = 4'd7;
	localparam logic [PhaseW-1:0] PH_W3 = 4'd8;
	localparam logic [PhaseW-1:0] PH_WA1 = 4'd9;
	localparam logic [PhaseW-1:0] PH_WA2 = 4'd10;
	localparam logic [PhaseW-1:0] PH_R1 = 4'd11;
	localparam logic [PhaseW-1:0] PH_R2 = 4'd12;
	localparam logic [PhaseW-1:0] PH_RA1 = 4'd13;
	localparam logic [PhaseW-1:0] PH_RA2 = 4'd14;

	localparam logic [0:0] REG_HALF = 1'b0;
	localparam logic [0:0] REG_POLL = 1'b1;

	typedef struct packed {
		logic [HalfW-1:0] half_period_ticks;
		logic [PollW-1:0] ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic [OpW-1:0] op;
		logic [ByteW-1:0] write_byte;
		logic ack_after_read;
		logic sda_level;
	} tick_t;

	typedef struct packed {
		logic [ByteW-1:0] read_byte;
		logic ack_error;
		logic done_res;
		logic busy_res;
		logic sda_pull_low;
		logic scl_level;
	} res_t;

endpackage

`default_nettype wire

>>> sv/i2c_bit_level_master_top.sv
// top level of the i2c bit level master: apb registers, pin sequencer, result queue
// depends on ibm_pkg, ibm_regs, ibm_engine, ibm_outq
//
// usage: every transaction on the s_ channel is one timebase tick. it carries the
// sampled sda level and, while the engine is idle, a command in s_tuser (start,
// stop, write byte with acknowledge poll, read byte then ack or nack). each tick
// yields exactly one result transaction on the m_ channel with the pin levels,
// busy, done, ack error and the received byte.
// each result is registered in the result queue and is shown on m_tdata from its head.
// throughput: one tick per cycle while the queue has room; the sequencer updates its
// state once per tick taken and a two entry result queue sits in front of the m_ channel.
// stalls: while m_tready is low the queue fills and s_tready drops once both
// entries are held; no tick is taken or lost meanwhile.
// reset: arst_n returns the engine to idle with scl and sda released, clears the queue
// and loads the registers with 100 ticks per delay step and a poll limit of 250. the
// user must write registers over apb only while the engine is idle; no check enforces it.
`default_nettype none

module i2c_bit_level_master_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// [7:0] write_byte, [8] ack_after_read, [9] sda_level, [15:10] zero
	input wire logic [ibm_pkg::InDataW-1:0] s_tdata,
	// [2:0] op
	input wire logic [ibm_pkg::OpW-1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res, [4] ack_error,
	// [12:5] read_byte, [15:13] zero
	output logic [ibm_pkg::OutDataW-1:0] m_tdata,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ibm_pkg::ApbAddrW-1:0] paddr,
	input wire logic [ibm_pkg::ApbDataW-1:0] pwdata,
	output logic [ibm_pkg::ApbDataW-1:0] prdata,
	output logic pready
);
	import ibm_pkg::*;

	cfg_t cfg;
	tick_t tick;
	res_t res, out_res;
	logic tick_en;

	assign tick.op = s_tuser;
	assign tick.write_byte = s_tdata[7:0];
	assign tick.ack_after_read = s_tdata[8];
	assign tick.sda_level = s_tdata[9];
	assign tick_en = s_tvalid && s_tready;

	ibm_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ibm_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.en(tick_en),
		.tick(tick),
		.cfg(cfg),
		.res(res)
	);

	ibm_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(tick_en),
		.push_data(res),
		.ready(s_tready),
		.valid(m_tvalid),
		.pop(m_tvalid && m_tready),
		.pop_data(out_res)
	);

	assign m_tdata = {{(OutDataW-$bits(res_t)){1'b0}}, out_res};

endmodule

`default_nettype wire

>>> sv/ibm_regs.sv
// apb configuration registers of the i2c bit level master
// depends on ibm_pkg
`default_nettype none

module ibm_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ibm_pkg::ApbAddrW-1:0] paddr,
	input wire logic [ibm_pkg::ApbDataW-1:0] pwdata,
	output logic [ibm_pkg::ApbDataW-1:0] prdata,
	output logic pready,
	output ibm_pkg::cfg_t cfg
);
	import ibm_pkg::*;

	logic [HalfW-1:0] half_q;
	logic [PollW-1:0] poll_q;
	logic wr_en;
	logic [0:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HalfReset;
			poll_q <= PollReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_HALF: half_q <= pwdata[HalfW-1:0];
				REG_POLL: poll_q <= pwdata[PollW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HALF: prdata = {{(ApbDataW-HalfW){1'b0}}, half_q};
			REG_POLL: prdata = {{(ApbDataW-PollW){1'b0}}, poll_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.half_period_ticks = half_q;
	assign cfg.ack_poll_limit = poll_q;

endmodule

`default_nettype wire

>>> sv/ibm_engine.sv
// pin sequencer of the i2c bit level master, one tick per accepted transaction
// depends on ibm_pkg
`default_nettype none

module ibm_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire ibm_pkg::tick_t tick,
	input wire ibm_pkg::cfg_t cfg,
	output ibm_pkg::res_t res
);
	import ibm_pkg::*;

	logic [PhaseW-1:0] ph_q, ph_d;
	logic [CmdW-1:0] cmd_q, cmd_d;
	logic [BitCntW-1:0] bits_q, bits_d, bits_inc;
	logic [ByteW-1:0] shift_q, shift_d;
	logic [HalfW-1:0] dly_q, dly_d;
	logic [PollW-1:0] poll_q, poll_d;
	logic scl_q, scl_d;
	logic sda_q, sda_d;
	logic done, err;
	logic [ByteW-1:0] rb;

	assign bits_inc = bits_q + 4'd1;

	always_comb begin
		ph_d = ph_q;
		cmd_d = cmd_q;
		bits_d = bits_q;
		shift_d = shift_q;
		dly_d = dly_q;
		poll_d = poll_q;
		scl_d = scl_q;
		sda_d = sda_q;
		done = 1'b0;
		err = 1'b0;
		rb = '0;
		if (ph_q == PH_IDLE) begin
			unique case (tick.op)
				OP_START: begin
					cmd_d = CMD_START;
					sda_d = 1'b1;
					scl_d = 1'b1;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_ST1;
				end
				OP_STOP: begin
					cmd_d = CMD_STOP;
					scl_d = 1'b0;
					sda_d = 1'b0;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_SP1;
				end
				OP_WRITE: begin
					cmd_d = CMD_WRITE;
					shift_d = tick.write_byte;
					bits_d = '0;
					poll_d = '0;
					scl_d = 1'b0;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_W1;
				end
				OP_READ: begin
					cmd_d = tick.ack_after_read ? CMD_READ_ACK : CMD_READ_NACK;
					shift_d = '0;
					bits_d = '0;
					sda_d = 1'b1;
					scl_d = 1'b0;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_R1;
				end
				default: ;
			endcase
		end else if (dly_q > 16'd1) begin
			dly_d = dly_q - 16'd1;
		end else begin
			dly_d = '0;
			unique case (ph_q)
				PH_ST1: begin
					sda_d = 1'b0;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_ST2;
				end
				PH_ST2: begin
					scl_d = 1'b0;
					ph_d = PH_IDLE;
					done = 1'b1;
				end
				PH_SP1: begin
					scl_d = 1'b1;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_SP2;
				end
				PH_SP2: begin
					sda_d = 1'b1;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_SP3;
				end
				PH_SP3: begin
					ph_d = PH_IDLE;
					done = 1'b1;
					err = (cmd_q == CMD_WRITE);
				end
				PH_W1: begin
					sda_d = shift_q[ByteW-1];
					shift_d = {shift_q[ByteW-2:0], 1'b0};
					dly_d = cfg.half_period_ticks;
					ph_d = PH_W2;
				end
				PH_W2: begin
					scl_d = 1'b1;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_W3;
				end
				PH_W3: begin
					scl_d = 1'b0;
					bits_d = bits_inc;
					dly_d = cfg.half_period_ticks;
					if (bits_inc < BitsPerByte) begin
						ph_d = PH_W1;
					end else begin
						sda_d = 1'b1;
						ph_d = PH_WA1;
					end
				end
				PH_WA1: begin
					scl_d = 1'b1;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_WA2;
				end
				PH_WA2: begin
					if (!tick.sda_level) begin
						scl_d = 1'b0;
						ph_d = PH_IDLE;
						done = 1'b1;
					end else if (poll_q >= cfg.ack_poll_limit) begin
						// no acknowledge in time, fall into the stop sequence
						scl_d = 1'b0;
						sda_d = 1'b0;
						dly_d = cfg.half_period_ticks;
						ph_d = PH_SP1;
					end else begin
						poll_d = poll_q + 8'd1;
					end
				end
				PH_R1: begin
					scl_d = 1'b1;
					shift_d = {shift_q[ByteW-1:1], shift_q[0] | tick.sda_level};
					dly_d = cfg.half_period_ticks;
					ph_d = PH_R2;
				end
				PH_R2: begin
					bits_d = bits_inc;
					scl_d = 1'b0;
					dly_d = cfg.half_period_ticks;
					if (bits_inc < BitsPerByte) begin
						shift_d = {shift_q[ByteW-2:0], 1'b0};
						ph_d = PH_R1;
					end else begin
						sda_d = (cmd_q != CMD_READ_ACK);
						ph_d = PH_RA1;
					end
				end
				PH_RA1: begin
					scl_d = 1'b1;
					dly_d = cfg.half_period_ticks;
					ph_d = PH_RA2;
				end
				PH_RA2: begin
					scl_d = 1'b0;
					ph_d = PH_IDLE;
					done = 1'b1;
					rb = shift_q;
				end
				default: ph_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			cmd_q <= CMD_NONE;
			bits_q <= '0;
			shift_q <= '0;
			dly_q <= '0;
			poll_q <= '0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
		end else if (en) begin
			ph_q <= ph_d;
			cmd_q <= cmd_d;
			bits_q <= bits_d;
			shift_q <= shift_d;
			dly_q <= dly_d;
			poll_q <= poll_d;
			scl_q <= scl_d;
			sda_q <= sda_d;
		end
	end

	assign res.scl_level = scl_d;
	assign res.sda_pull_low = ~sda_d;
	assign res.busy_res = (ph_d != PH_IDLE);
	assign res.done_res = done;
	assign res.ack_error = err;
	assign res.read_byte = rb;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done_res |-> !res.busy_res)
		else $error("done while still busy");
	a_err_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res.ack_error |-> (ph_q == PH_SP3) && (cmd_q == CMD_WRITE))
		else $error("ack error outside write stop");
	a_rb_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res.read_byte != '0) |-> res.done_res && (ph_q == PH_RA2))
		else $error("read byte outside read completion");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ph_q) && $stable(dly_q))
		else $error("state moved without a tick");
`endif

endmodule

`default_nettype wire

>>> sv/ibm_outq.sv
// two entry result queue between the sequencer and the output stream
// depends on ibm_pkg
`default_nettype none

module ibm_outq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire ibm_pkg::res_t push_data,
	output logic ready,
	output logic valid,
	input wire logic pop,
	output ibm_pkg::res_t pop_data
);
	import ibm_pkg::*;

	res_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end else begin
				cnt_q <= cnt_q;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push)
		else $error("push into full queue");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step");
`endif

endmodule

`default_nettype wire
